// ===== src/cobs_pkg.sv =====
// shared types, codes and the crc step for the cobs frame decoder
// no dependencies; imported by cobs_crc_frame_decoder and the testbench
package cobs_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_CRC       = 2'd3
  } status_e;

  // decoder sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_READ  = 4'b0100,
    S_LOAD  = 4'b1000
  } state_e;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] CRC_MSB         = 16'h8000;
  localparam logic [7:0]  CODE_FULL       = 8'hFF;
  localparam logic [7:0]  BYTE_ZERO       = 8'h00;
  localparam logic [7:0]  HEADER_PLUS_CRC = 8'd5;
  localparam logic [6:0]  BLOCK_COUNT_MAX = 7'd127;

  // crc-16/ccitt-false, one byte msb first
  function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/cobs_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies; holds the decoded frame body
module cobs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 37
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cobs_crc_frame_decoder.sv =====
// cobs block decoder with length and crc-16/ccitt-false check
// one link beat per cycle while idle; at block end a check state, then per payload beat
// a body ram read state and an output register load state; error or empty frames give
// one result beat. input stalls from block end until the last result is loaded.
// reset: asynchronous, clears the sequencer, per-block state and the output valid;
// the body ram has no reset, only entries written in the current block are read
// depends on cobs_pkg and cobs_ram
module cobs_crc_frame_decoder
  import cobs_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = 32,
  parameter int MAX_BLOCK_BYTES   = 38,
  parameter int BODY_DEPTH        = 37
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] link_byte_i,
  input  logic       block_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] command_o,
  output logic [7:0] sequence_res_o,
  output logic [5:0] payload_length_o,
  output logic [7:0] payload_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o
);

  localparam int AW = $clog2(BODY_DEPTH);
  localparam int CW = $clog2(BODY_DEPTH + 1);
  localparam int KW = $clog2(MAX_PAYLOAD_BYTES + 1);

  state_e        state_q, state_d;
  logic [7:0]    run_q, run_d;
  logic          zp_q, zp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [6:0]    blk_q, blk_d;
  status_e       ferr_q, ferr_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    tail0_q, tail0_d, tail1_q, tail1_d;
  logic [7:0]    cmd_q, cmd_d, seq_q, seq_d, len_q, len_d;
  logic [KW-1:0] k_q, k_d;

  logic          out_valid_q, out_valid_d;
  status_e       o_status_q, o_status_d;
  logic [7:0]    o_cmd_q, o_cmd_d, o_seq_q, o_seq_d, o_byte_q, o_byte_d;
  logic [5:0]    o_len_q, o_len_d;
  logic          o_bvalid_q, o_bvalid_d, o_last_q, o_last_d;

  logic          in_acc, full, push, push_ok, out_free, clear;
  logic [7:0]    push_byte;
  status_e       chk_st;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          pay_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q >= CW'(BODY_DEPTH));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign push_ok    = push && !full;
  assign ram_raddr  = AW'(k_q) + AW'(3);
  assign pay_last   = ((8'(k_q) + 8'd1) == len_q);

  // body store
  cobs_ram #(
    .WIDTH(8),
    .DEPTH(BODY_DEPTH)
  ) u_body (
    .clk_i  (clk_i),
    .we_i   (push_ok),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(push_byte),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // end of block checks, first failing check decides
  always_comb begin
    priority if (blk_q < 7'd2 || blk_q > 7'(MAX_BLOCK_BYTES)) begin
      chk_st = ST_MALFORMED;
    end else if (ferr_q != ST_OK) begin
      chk_st = ferr_q;
    end else if (run_q != 8'd0) begin
      chk_st = ST_MALFORMED;
    end else if (8'(cnt_q) < HEADER_PLUS_CRC) begin
      chk_st = ST_MALFORMED;
    end else if (len_q > 8'(MAX_PAYLOAD_BYTES)) begin
      chk_st = ST_MALFORMED;
    end else if (9'(cnt_q) != ({1'b0, len_q} + {1'b0, HEADER_PLUS_CRC})) begin
      chk_st = ST_MALFORMED;
    end else if ({tail1_q, tail0_q} != crc_q) begin
      chk_st = ST_CRC;
    end else begin
      chk_st = ST_OK;
    end
  end

  // cobs unstuffing, crc and sequencer
  always_comb begin
    state_d   = state_q;
    run_d     = run_q;
    zp_d      = zp_q;
    cnt_d     = cnt_q;
    blk_d     = blk_q;
    ferr_d    = ferr_q;
    crc_d     = crc_q;
    tail0_d   = tail0_q;
    tail1_d   = tail1_q;
    cmd_d     = cmd_q;
    seq_d     = seq_q;
    len_d     = len_q;
    k_d       = k_q;
    push      = 1'b0;
    push_byte = BYTE_ZERO;
    clear     = 1'b0;
    ram_re    = 1'b0;

    out_valid_d = out_valid_q && out_stall_i;
    o_status_d  = o_status_q;
    o_cmd_d     = o_cmd_q;
    o_seq_d     = o_seq_q;
    o_len_d     = o_len_q;
    o_byte_d    = o_byte_q;
    o_bvalid_d  = o_bvalid_q;
    o_last_d    = o_last_q;

    // link beat
    if (in_acc) begin
      if (blk_q != BLOCK_COUNT_MAX) begin
        blk_d = blk_q + 7'd1;
      end
      if (ferr_q == ST_OK) begin
        if (run_q == 8'd0) begin
          if (zp_q) begin
            zp_d = 1'b0;
            push = 1'b1;
          end
          if (zp_q && full) begin
            ferr_d = ST_OVERFLOW;
          end else if (link_byte_i == BYTE_ZERO) begin
            ferr_d = ST_MALFORMED;
          end else begin
            run_d = link_byte_i - 8'd1;
            zp_d  = (link_byte_i != CODE_FULL);
          end
        end else begin
          push      = 1'b1;
          push_byte = link_byte_i;
          if (full) begin
            ferr_d = ST_OVERFLOW;
          end else begin
            run_d = run_q - 8'd1;
          end
        end
      end
      if (block_end_i) begin
        state_d = S_CHECK;
      end
    end

    // body append with two byte crc delay line
    if (push_ok) begin
      if (cnt_q >= CW'(2)) begin
        crc_d = crc_absorb(crc_q, tail0_q);
      end
      tail0_d = tail1_q;
      tail1_d = push_byte;
      cnt_d   = cnt_q + CW'(1);
      if (cnt_q == CW'(0)) cmd_d = push_byte;
      if (cnt_q == CW'(1)) seq_d = push_byte;
      if (cnt_q == CW'(2)) len_d = push_byte;
    end

    // result sequencing
    unique case (state_q)
      S_IDLE: begin
      end
      S_CHECK: begin
        if (chk_st == ST_OK && len_q != 8'd0) begin
          k_d     = '0;
          state_d = S_READ;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = chk_st;
          o_cmd_d     = (chk_st == ST_OK) ? cmd_q : 8'd0;
          o_seq_d     = (chk_st == ST_OK) ? seq_q : 8'd0;
          o_len_d     = 6'd0;
          o_byte_d    = 8'd0;
          o_bvalid_d  = 1'b0;
          o_last_d    = 1'b1;
          clear       = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = ST_OK;
          o_cmd_d     = cmd_q;
          o_seq_d     = seq_q;
          o_len_d     = len_q[5:0];
          o_byte_d    = ram_rdata;
          o_bvalid_d  = 1'b1;
          o_last_d    = pay_last;
          if (pay_last) begin
            clear   = 1'b1;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // per-block state back to reset values
    if (clear) begin
      run_d   = 8'd0;
      zp_d    = 1'b0;
      cnt_d   = '0;
      blk_d   = 7'd0;
      ferr_d  = ST_OK;
      crc_d   = CRC_INIT;
      tail0_d = 8'd0;
      tail1_d = 8'd0;
    end
  end

  // control and block state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= 8'd0;
      zp_q        <= 1'b0;
      cnt_q       <= '0;
      blk_q       <= 7'd0;
      ferr_q      <= ST_OK;
      crc_q       <= CRC_INIT;
      tail0_q     <= 8'd0;
      tail1_q     <= 8'd0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      zp_q        <= zp_d;
      cnt_q       <= cnt_d;
      blk_q       <= blk_d;
      ferr_q      <= ferr_d;
      crc_q       <= crc_d;
      tail0_q     <= tail0_d;
      tail1_q     <= tail1_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // header and output payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    seq_q      <= seq_d;
    len_q      <= len_d;
    o_status_q <= o_status_d;
    o_cmd_q    <= o_cmd_d;
    o_seq_q    <= o_seq_d;
    o_len_q    <= o_len_d;
    o_byte_q   <= o_byte_d;
    o_bvalid_q <= o_bvalid_d;
    o_last_q   <= o_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign command_o        = o_cmd_q;
  assign sequence_res_o   = o_seq_q;
  assign payload_length_o = o_len_q;
  assign payload_byte_o   = o_byte_q;
  assign byte_valid_o     = o_bvalid_q;
  assign run_last_o       = o_last_q;

endmodule

// ===== verif/testbench.sv =====
// testbench for cobs_crc_frame_decoder: good frames, cobs and frame errors, noise and stalls
// every result beat is checked against an in-bench decoder model, field by field
// depends on cobs_pkg and the decoder rtl only
`timescale 1ns / 100ps

module testbench;
  import cobs_pkg::*;

  localparam int MAX_PAYLOAD    = 32;
  localparam int MAX_BLOCK      = 38;
  localparam int BODY_DEPTH     = 37;
  localparam int IDLE_LIMIT     = 5000;
  localparam int RANDOM_BEATS   = 30;
  localparam int RANDOM_RESULTS = 8;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 20;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_HEAVY
  } rx_pattern_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] command;
    logic [7:0] sequence_res;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       run_last;
  } frame_beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] link_byte_i = 8'h00;
  logic       block_end_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic [7:0] command_o;
  logic [7:0] sequence_res_o;
  logic [5:0] payload_length_o;
  logic [7:0] payload_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;

  cobs_crc_frame_decoder #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD),
    .MAX_BLOCK_BYTES  (MAX_BLOCK),
    .BODY_DEPTH       (BODY_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .link_byte_i     (link_byte_i),
    .block_end_i     (block_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .command_o       (command_o),
    .sequence_res_o  (sequence_res_o),
    .payload_length_o(payload_length_o),
    .payload_byte_o  (payload_byte_o),
    .byte_valid_o    (byte_valid_o),
    .run_last_o      (run_last_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // decoder model state, one block at a time
  logic [7:0]  body_mem [BODY_DEPTH];
  logic [7:0]  run_left;
  logic        zero_owed;
  int          body_n;
  int          beats_in_block;
  status_e     sticky_err;
  logic [15:0] crc_acc;
  logic [7:0]  tail_lo;
  logic [7:0]  tail_hi;

  frame_beat_t pending_frame_beats[$];
  frame_beat_t want_beat;
  int          fail_count;
  int          result_beats_seen;
  int          link_beats_sent;

  // stimulus scratch
  logic [7:0] body_q[$];
  logic [7:0] link_q[$];
  int         burst_left;
  bit         gaps_on = 1'b1;

  // receiver stall pattern and long hold-off
  rx_pattern_e rx_kind;
  int          rx_left;
  int          rx_phase;
  int          rx_period;
  int          hold_len;
  int          hold_left;
  int          hold_seen;
  int          hold_req_n = 0;
  bit          stall_next;
  int          idle_cycles;

  // crc-16/ccitt-false, one bit at a time msb first
  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      if (c[15] ^ d[i]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void clear_block_state();
    run_left       = 8'd0;
    zero_owed      = 1'b0;
    body_n         = 0;
    beats_in_block = 0;
    sticky_err     = ST_OK;
    crc_acc        = CRC_INIT;
    tail_lo        = 8'h00;
    tail_hi        = 8'h00;
  endfunction

  // append to the body; crc trails by two bytes so the tail is the received crc
  function automatic bit store_body_byte(input logic [7:0] b);
    if (body_n >= BODY_DEPTH) return 1'b0;
    if (body_n >= 2) crc_acc = crc_ccitt_byte(crc_acc, tail_lo);
    tail_lo = tail_hi;
    tail_hi = b;
    body_mem[body_n] = b;
    body_n++;
    return 1'b1;
  endfunction

  // undo cobs one link byte at a time
  function automatic void unstuff_byte(input logic [7:0] b);
    if (run_left == 8'd0) begin
      // implied zero only lands once another code byte shows up
      if (zero_owed) begin
        zero_owed = 1'b0;
        if (!store_body_byte(BYTE_ZERO)) begin
          sticky_err = ST_OVERFLOW;
          return;
        end
      end
      if (b == BYTE_ZERO) begin
        sticky_err = ST_MALFORMED;
        return;
      end
      run_left  = b - 8'd1;
      zero_owed = (b != CODE_FULL);
    end else begin
      if (!store_body_byte(b)) begin
        sticky_err = ST_OVERFLOW;
        return;
      end
      run_left = run_left - 8'd1;
    end
  endfunction

  // block length first, then cobs errors, body shape, length field, crc
  function automatic status_e block_verdict();
    int plen;
    if (beats_in_block < 2 || beats_in_block > MAX_BLOCK) return ST_MALFORMED;
    if (sticky_err != ST_OK) return sticky_err;
    if (run_left != 8'd0) return ST_MALFORMED;
    if (body_n < int'(HEADER_PLUS_CRC)) return ST_MALFORMED;
    plen = int'(body_mem[2]);
    if (plen > MAX_PAYLOAD) return ST_MALFORMED;
    if (body_n != plen + int'(HEADER_PLUS_CRC)) return ST_MALFORMED;
    if ({tail_hi, tail_lo} != crc_acc) return ST_CRC;
    return ST_OK;
  endfunction

  // model one accepted link beat and queue the result beats it causes
  function automatic void decode_link_beat(input logic [7:0] b, input logic last);
    frame_beat_t beat;
    status_e     verdict;
    int          plen;
    if (beats_in_block < int'(BLOCK_COUNT_MAX)) beats_in_block++;
    if (sticky_err == ST_OK) unstuff_byte(b);
    if (!last) return;
    verdict = block_verdict();
    beat = '0;
    beat.status   = verdict;
    beat.run_last = 1'b1;
    plen = 0;
    if (verdict == ST_OK) begin
      beat.command      = body_mem[0];
      beat.sequence_res = body_mem[1];
      plen = int'(body_mem[2]);
    end
    if (plen == 0) begin
      pending_frame_beats.push_back(beat);
    end else begin
      for (int k = 0; k < plen; k++) begin
        beat.payload_length = 6'(plen);
        beat.payload_byte   = body_mem[3 + k];
        beat.byte_valid     = 1'b1;
        beat.run_last       = (k == plen - 1);
        pending_frame_beats.push_back(beat);
      end
    end
    clear_block_state();
  endfunction

  // result checking and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      result_beats_seen++;
      if (pending_frame_beats.size() == 0) begin
        $error("result beat with nothing expected: status %0d byte %0h", status_o,
               payload_byte_o);
        fail_count++;
      end else begin
        want_beat = pending_frame_beats.pop_front();
        if (status_o !== want_beat.status) begin
          $error("status: expected %0d, got %0d", want_beat.status, status_o);
          fail_count++;
        end
        if (command_o !== want_beat.command) begin
          $error("command: expected %0h, got %0h", want_beat.command, command_o);
          fail_count++;
        end
        if (sequence_res_o !== want_beat.sequence_res) begin
          $error("sequence_res: expected %0h, got %0h", want_beat.sequence_res,
                 sequence_res_o);
          fail_count++;
        end
        if (payload_length_o !== want_beat.payload_length) begin
          $error("payload_length: expected %0d, got %0d", want_beat.payload_length,
                 payload_length_o);
          fail_count++;
        end
        if (payload_byte_o !== want_beat.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want_beat.payload_byte,
                 payload_byte_o);
          fail_count++;
        end
        if (byte_valid_o !== want_beat.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want_beat.byte_valid, byte_valid_o);
          fail_count++;
        end
        if (run_last_o !== want_beat.run_last) begin
          $error("run_last: expected %0d, got %0d", want_beat.run_last, run_last_o);
          fail_count++;
        end
      end
    end

    // a new hold-off request starts a long stall counted here
    if (hold_req_n != hold_seen) begin
      hold_seen = hold_req_n;
      hold_left = hold_len;
    end
    if (rx_left == 0) begin
      rx_kind   = rx_pattern_e'($urandom_range(0, 3));
      rx_left   = $urandom_range(16, 96);
      rx_period = $urandom_range(2, 7);
    end
    rx_left--;
    rx_phase++;
    if (hold_left > 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else begin
      case (rx_kind)
        RX_FREE:     stall_next = 1'b0;
        RX_RANDOM:   stall_next = ($urandom_range(0, 2) == 0);
        RX_PERIODIC: stall_next = ((rx_phase % rx_period) < rx_period / 2);
        default:     stall_next = ($urandom_range(0, 7) != 0);
      endcase
    end
    out_stall_i <= stall_next;
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // any byte value, evenly spread
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // data byte with extra weight on zero and 0xff
  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 9))
      0, 1:    return BYTE_ZERO;
      2:       return CODE_FULL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // cobs-encode body_q into link_q, no delimiter
  task automatic cobs_encode();
    int         code_at;
    logic [7:0] run;
    link_q.delete();
    link_q.push_back(BYTE_ZERO);
    code_at = 0;
    run     = 8'd1;
    foreach (body_q[i]) begin
      if (body_q[i] == BYTE_ZERO) begin
        link_q[code_at] = run;
        link_q.push_back(BYTE_ZERO);
        code_at = link_q.size() - 1;
        run     = 8'd1;
      end else begin
        link_q.push_back(body_q[i]);
        run++;
      end
    end
    link_q[code_at] = run;
  endtask

  // body of command, sequence, length, payload, crc little-endian, then encoded
  task automatic build_frame(input logic [7:0] cmd, input logic [7:0] seq, input int n_pay,
                             input logic [7:0] len_field, input bit bad_crc);
    logic [15:0] crc;
    body_q.delete();
    body_q.push_back(cmd);
    body_q.push_back(seq);
    body_q.push_back(len_field);
    repeat (n_pay) body_q.push_back(rand_data());
    crc = CRC_INIT;
    foreach (body_q[i]) crc = crc_ccitt_byte(crc, body_q[i]);
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    body_q.push_back(crc[7:0]);
    body_q.push_back(crc[15:8]);
    cobs_encode();
  endtask

  // one link beat, with the sender's burst and gap pacing in front
  task automatic send_link_beat(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    link_byte_i <= b;
    block_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    link_beats_sent++;
    decode_link_beat(b, last);
  endtask

  task automatic send_block();
    foreach (link_q[i]) send_link_beat(link_q[i], i == link_q.size() - 1);
  endtask

  task automatic send_noise(input int n);
    link_q.delete();
    repeat (n) link_q.push_back(rand_data());
    send_block();
  endtask

  task automatic wait_frames_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_frame_beats.size() != 0);
  endtask

  // well-formed frames at the size and field extremes
  task automatic test_good_frames();
    build_frame(8'h00, 8'hFF, 0, 8'd0, 1'b0);
    send_block();
    build_frame(8'hFF, 8'h00, 1, 8'd1, 1'b0);
    send_block();
    build_frame(rand_byte(), rand_byte(), MAX_PAYLOAD, 8'(MAX_PAYLOAD), 1'b0);
    send_block();
  endtask

  // block length limits, counter saturation on very long blocks
  task automatic test_block_length();
    send_noise(1);
    link_q.delete();
    link_q.push_back(8'h01);
    link_q.push_back(8'h01);
    send_block();
    // largest good frame plus one code byte goes one past the limit
    build_frame(rand_byte(), rand_byte(), MAX_PAYLOAD, 8'(MAX_PAYLOAD), 1'b0);
    link_q.push_back(8'h01);
    send_block();
    // body overflow only happens inside blocks that are already too long
    link_q.delete();
    link_q.push_back(CODE_FULL);
    repeat (44) link_q.push_back(rand_data());
    send_block();
    send_noise(130);
  endtask

  task automatic test_cobs_errors();
    // zero code byte up front, the rest of the block is only counted
    build_frame(rand_byte(), rand_byte(), 4, 8'd4, 1'b0);
    link_q[0] = BYTE_ZERO;
    send_block();
    // zero code byte later on wins over the broken crc
    build_frame(rand_byte(), rand_byte(), 6, 8'd6, 1'b0);
    body_q[3] = BYTE_ZERO;
    cobs_encode();
    link_q[link_q[0]] = BYTE_ZERO;
    send_block();
    // run still open at block end
    link_q.delete();
    link_q.push_back(8'h06);
    repeat (3) link_q.push_back(rand_data());
    send_block();
    link_q.delete();
    link_q.push_back(CODE_FULL);
    repeat (10) link_q.push_back(8'($urandom_range(1, 255)));
    send_block();
    // trailing code byte forces the pending zero into the body
    build_frame(rand_byte(), rand_byte(), 3, 8'd3, 1'b0);
    link_q.push_back(8'h01);
    send_block();
  endtask

  task automatic test_body_checks();
    // short body
    body_q.delete();
    repeat (4) body_q.push_back(rand_data());
    cobs_encode();
    send_block();
    // length field above the limit
    build_frame(rand_byte(), rand_byte(), 2, 8'd33, 1'b0);
    send_block();
    build_frame(rand_byte(), rand_byte(), 0, 8'hFF, 1'b0);
    send_block();
    // length field off by one either way
    build_frame(rand_byte(), rand_byte(), 5, 8'd6, 1'b0);
    send_block();
    build_frame(rand_byte(), rand_byte(), 5, 8'd4, 1'b0);
    send_block();
    // crc mismatch
    build_frame(rand_byte(), rand_byte(), 3, 8'd3, 1'b1);
    send_block();
    build_frame(rand_byte(), rand_byte(), 0, 8'd0, 1'b1);
    send_block();
  endtask

  // receiver holds off while frames keep coming, so the input side backs up
  task automatic test_backpressure();
    int n;
    hold_len   = LONG_HOLD;
    hold_req_n <= hold_req_n + 1;
    gaps_on    = 1'b0;
    repeat (2) begin
      n = $urandom_range(8, 16);
      build_frame(rand_byte(), rand_byte(), n, 8'(n), 1'b0);
      send_block();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    build_frame(rand_byte(), rand_byte(), 7, 8'd7, 1'b0);
    send_block();
    wait_frames_drained();
    build_frame(rand_byte(), rand_byte(), 2, 8'd2, 1'b0);
    send_block();
    wait_frames_drained();
  endtask

  // mostly well-formed frames with random content, the rest broken or noise
  task automatic test_random_traffic();
    int         beats_start;
    int         results_start;
    int         pick;
    int         n;
    logic [7:0] len_field;
    beats_start   = link_beats_sent;
    results_start = result_beats_seen;
    while (link_beats_sent - beats_start < RANDOM_BEATS ||
           result_beats_seen - results_start < RANDOM_RESULTS) begin
      pick = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAYLOAD) : $urandom_range(0, 6);
      if (pick < 65) begin
        build_frame(rand_byte(), rand_byte(), n, 8'(n), 1'b0);
        send_block();
      end else if (pick < 75) begin
        build_frame(rand_byte(), rand_byte(), n, 8'(n), 1'b1);
        send_block();
      end else if (pick < 83) begin
        len_field = 8'(n + $urandom_range(1, 255));
        build_frame(rand_byte(), rand_byte(), n, len_field, 1'b0);
        send_block();
      end else if (pick < 93) begin
        build_frame(rand_byte(), rand_byte(), n, 8'(n), 1'b0);
        case ($urandom_range(0, 2))
          0:       link_q[$urandom_range(0, link_q.size() - 1)] = rand_data();
          1:       link_q.pop_back();
          default: link_q.push_back(rand_data());
        endcase
        send_block();
      end else begin
        send_noise($urandom_range(1, 45));
      end
    end
  endtask

  initial begin
    clear_block_state();
    fail_count        = 0;
    result_beats_seen = 0;
    link_beats_sent   = 0;
    burst_left        = 0;
    rx_left           = 0;
    rx_phase          = 0;
    hold_len          = 0;
    hold_left         = 0;
    hold_seen         = 0;
    idle_cycles       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_good_frames();
    test_block_length();
    test_cobs_errors();
    test_body_checks();
    test_backpressure();
    test_pause_until_drained();
    test_random_traffic();

    wait_frames_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
